// ===== rtl/atsr_pkg.sv =====
`default_nettype none
package atsr_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int ADDR_W = 64;
   localparam int LEN_W = 32;
   localparam int KIND_W = 4;
   localparam int ID_W = 16;
   localparam logic [ADDR_W-1:0] WALK_LIMIT = 64'h0000_0000_0010_0000;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_RESOLVE = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_RSVD    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NONE    = 2'd1,
      STS_FULL    = 2'd2,
      STS_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      REG_IMAGE_BASE = 1'b0,
      REG_IMAGE_SIZE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  len;
      logic [KIND_W-1:0] kind;
      logic              func;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_OFS,
      ST_BS_RD,
      ST_BS_CMP,
      ST_WK_RD,
      ST_WK_CMP,
      ST_FB_RD,
      ST_FB_CMP,
      ST_INS_RD,
      ST_INS_CMP,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/atsr_mem.sv =====
`default_nettype none
module atsr_mem
   import atsr_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH_DEF,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/address_to_symbol_resolver.sv =====
`default_nettype none
// Resolve: setup (ST_LIMIT, ST_OFS), a binary search of up to ceil(log2(n+1)) probes,
// a walk back over the entries below the offset, then the result: a containing function,
// else the nearest entry at or below the offset, else none. Insert shifts entries up one
// slot per step until its slot is found; clear and other actions go straight to ST_DONE.
// One beat in flight; a stalled result holds the last step. Reset (synchronous, active
// high) empties the table and zeroes both image registers; table contents are kept.
module address_to_symbol_resolver
   import atsr_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_action,
   input  wire logic [ADDR_W-1:0] req_address,
   input  wire logic              req_address_is_offset,
   input  wire logic [LEN_W-1:0]  req_length,
   input  wire logic [KIND_W-1:0] req_kind_code,
   input  wire logic              req_is_function,
   input  wire logic [ID_W-1:0]   req_entry_id,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [ID_W-1:0]        rsp_found_id,
   output logic [ADDR_W-1:0]      rsp_found_start,
   output logic [ADDR_W-1:0]      rsp_offset_into,
   output logic [ADDR_W-1:0]      rsp_image_offset,
   output logic [ADDR_W-1:0]      rsp_full_address,
   output logic                   rsp_by_containment,

   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [ADDR_W-1:0] csr_data
);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] base_ff, size_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, k_ff, k_in, pos_ff, pos_in;

   entry_type         ent_ff, ent_in;
   logic              is_off_ff, is_off_in;
   logic [ADDR_W-1:0] lim_ff, lim_in, off_ff, off_in, full_ff, full_in;

   logic              rv_ff, rv_in;
   logic [1:0]        st_ff, st_in;
   logic [ID_W-1:0]   fid_ff, fid_in;
   logic [ADDR_W-1:0] fst_ff, fst_in, oin_ff, oin_in, iof_ff, iof_in, fad_ff, fad_in;
   logic              bc_ff, bc_in;

   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_wa, mem_ra;
   entry_type         mem_wd, rd;

   logic [CNT_W-1:0]  mid;
   logic [ADDR_W-1:0] delta;
   logic              rd_ahead;
   logic              req_acc;

   atsr_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (rd)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign delta = off_ff - rd.start;

   always_comb begin
      if (rd.start != ent_ff.start) begin
         rd_ahead = rd.start < ent_ff.start;
      end else if (rd.len != ent_ff.len) begin
         rd_ahead = rd.len > ent_ff.len;
      end else begin
         rd_ahead = rd.kind <= ent_ff.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
         base_ff  <= '0;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         if (csr_valid && csr_ready) begin
            if (reg_index_type'(csr_index) == REG_IMAGE_BASE) begin
               base_ff <= csr_data;
            end else begin
               size_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      k_ff      <= k_in;
      pos_ff    <= pos_in;
      ent_ff    <= ent_in;
      is_off_ff <= is_off_in;
      lim_ff    <= lim_in;
      off_ff    <= off_in;
      full_ff   <= full_in;
      st_ff     <= st_in;
      fid_ff    <= fid_in;
      fst_ff    <= fst_in;
      oin_ff    <= oin_in;
      iof_ff    <= iof_in;
      fad_ff    <= fad_in;
      bc_ff     <= bc_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      ent_in    = ent_ff;
      is_off_in = is_off_ff;
      lim_in    = lim_ff;
      off_in    = off_ff;
      full_in   = full_ff;
      st_in     = st_ff;
      fid_in    = fid_ff;
      fst_in    = fst_ff;
      oin_in    = oin_ff;
      iof_in    = iof_ff;
      fad_in    = fad_ff;
      bc_in     = bc_ff;
      rv_in     = rv_ff && rsp_stall;
      mem_we    = 1'b0;
      mem_wa    = pos_ff[IDX_W-1:0];
      mem_wd    = ent_ff;
      mem_re    = 1'b0;
      mem_ra    = mid[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ent_in.start = req_address;
               ent_in.len   = req_length;
               ent_in.kind  = req_kind_code;
               ent_in.func  = req_is_function;
               ent_in.id    = req_entry_id;
               is_off_in    = req_address_is_offset;
               st_in        = STS_OK;
               fid_in       = '0;
               fst_in       = '0;
               oin_in       = '0;
               iof_in       = '0;
               fad_in       = '0;
               bc_in        = 1'b0;
               pos_in       = cnt_ff;
               state_in     = ST_DONE;
               unique case (action_type'(req_action))
                  ACT_INSERT: begin
                     if (req_address == '0) begin
                        st_in = STS_IGNORED;
                     end else if (cnt_ff >= CNT_W'(TABLE_DEPTH)) begin
                        st_in = STS_FULL;
                     end else begin
                        state_in = ST_INS_RD;
                     end
                  end
                  ACT_RESOLVE: state_in = ST_LIMIT;
                  ACT_CLEAR:   cnt_in = '0;
                  ACT_RSVD:    ;
                  default:     ;
               endcase
            end
         end

         ST_LIMIT: begin
            lim_in   = base_ff + size_ff;
            state_in = ST_OFS;
         end

         ST_OFS: begin
            off_in  = ent_ff.start;
            full_in = ent_ff.start;
            if (is_off_ff) begin
               if (base_ff != '0) begin
                  full_in = base_ff + ent_ff.start;
               end
            end else if (base_ff != '0 && ent_ff.start >= base_ff && ent_ff.start < lim_ff) begin
               off_in = ent_ff.start - base_ff;
            end
            lo_in    = '0;
            hi_in    = cnt_ff;
            state_in = ST_BS_RD;
         end

         ST_BS_RD: begin
            if (lo_ff < hi_ff) begin
               mem_re   = 1'b1;
               state_in = ST_BS_CMP;
            end else begin
               k_in     = lo_ff;
               state_in = ST_WK_RD;
            end
         end

         ST_BS_CMP: begin
            if (rd.start <= off_ff) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_BS_RD;
         end

         ST_WK_RD: begin
            if (k_ff == '0) begin
               state_in = ST_FB_RD;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = IDX_W'(k_ff - CNT_W'(1));
               k_in     = k_ff - CNT_W'(1);
               state_in = ST_WK_CMP;
            end
         end

         ST_WK_CMP: begin
            state_in = ST_WK_RD;
            if (rd.func && rd.start <= off_ff) begin
               if (rd.len == '0) begin
                  if (delta == '0) begin
                     bc_in    = 1'b1;
                     state_in = ST_FB_CMP;
                  end
               end else if (delta < {{(ADDR_W-LEN_W){1'b0}}, rd.len}) begin
                  bc_in    = 1'b1;
                  state_in = ST_FB_CMP;
               end else if (delta > WALK_LIMIT) begin
                  state_in = ST_FB_RD;
               end
            end
         end

         ST_FB_RD: begin
            if (lo_ff == '0) begin
               st_in    = STS_NONE;
               iof_in   = off_ff;
               fad_in   = full_ff;
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = IDX_W'(lo_ff - CNT_W'(1));
               state_in = ST_FB_CMP;
            end
         end

         // rd holds the chosen entry, either a walk hit or the fallback
         ST_FB_CMP: begin
            st_in    = STS_OK;
            fid_in   = rd.id;
            fst_in   = rd.start;
            oin_in   = delta;
            iof_in   = off_ff;
            fad_in   = full_ff;
            state_in = ST_DONE;
         end

         ST_INS_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = IDX_W'(pos_ff - CNT_W'(1));
               state_in = ST_INS_CMP;
            end
         end

         ST_INS_CMP: begin
            mem_we = 1'b1;
            if (rd_ahead) begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               mem_wd   = rd;
               pos_in   = pos_ff - CNT_W'(1);
               state_in = ST_INS_RD;
            end
         end

         ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // result register: outputs hold while stalled since fields load only in ST_DONE's hand-off
   logic [1:0]        o_st;
   logic [ID_W-1:0]   o_fid;
   logic [ADDR_W-1:0] o_fst, o_oin, o_iof, o_fad;
   logic              o_bc;

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rv_ff || !rsp_stall)) begin
         o_st  <= st_ff;
         o_fid <= fid_ff;
         o_fst <= fst_ff;
         o_oin <= oin_ff;
         o_iof <= iof_ff;
         o_fad <= fad_ff;
         o_bc  <= bc_ff;
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = o_st;
   assign rsp_found_id       = o_fid;
   assign rsp_found_start    = o_fst;
   assign rsp_offset_into    = o_oin;
   assign rsp_image_offset   = o_iof;
   assign rsp_full_address   = o_fad;
   assign rsp_by_containment = o_bc;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BS_RD || state_ff == ST_BS_CMP) |-> (lo_ff <= hi_ff && hi_ff <= cnt_ff))
      else $error("binary search bounds crossed");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_action == ACT_CLEAR) |=> cnt_ff == '0)
      else $error("clear did not empty table");

   a_write_only_insert: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_INS_RD || state_ff == ST_INS_CMP))
      else $error("table write outside insert");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import atsr_pkg::*;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] address;
      logic              is_offset;
      logic [LEN_W-1:0]  length;
      logic [KIND_W-1:0] kind;
      logic              is_func;
      logic [ID_W-1:0]   id;
   } lookup_req_t;

   typedef struct packed {
      logic [1:0]        status;
      logic [ID_W-1:0]   found_id;
      logic [ADDR_W-1:0] found_start;
      logic [ADDR_W-1:0] offset_into;
      logic [ADDR_W-1:0] image_offset;
      logic [ADDR_W-1:0] full_address;
      logic              by_containment;
   } lookup_rsp_t;

   typedef struct packed {
      lookup_req_t req;
      logic        typed;
      lookup_rsp_t rsp;
   } directed_row_t;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam logic [ADDR_W-1:0] ALL1 = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_action = ACT_INSERT;
   logic [ADDR_W-1:0] req_address = '0;
   logic              req_address_is_offset = 1'b0;
   logic [LEN_W-1:0]  req_length = '0;
   logic [KIND_W-1:0] req_kind_code = '0;
   logic              req_is_function = 1'b0;
   logic [ID_W-1:0]   req_entry_id = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [ID_W-1:0]   rsp_found_id;
   logic [ADDR_W-1:0] rsp_found_start;
   logic [ADDR_W-1:0] rsp_offset_into;
   logic [ADDR_W-1:0] rsp_image_offset;
   logic [ADDR_W-1:0] rsp_full_address;
   logic              rsp_by_containment;

   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = REG_IMAGE_BASE;
   logic [ADDR_W-1:0] csr_data = '0;

   address_to_symbol_resolver DUT (.*);

   always #5 clock = ~clock;

   // shadow of the symbol table
   logic [ADDR_W-1:0] sym_start [DEPTH];
   logic [LEN_W-1:0]  sym_len [DEPTH];
   logic [KIND_W-1:0] sym_kind [DEPTH];
   logic              sym_func [DEPTH];
   logic [ID_W-1:0]   sym_id [DEPTH];
   int unsigned       sym_count = 0;
   logic [ADDR_W-1:0] img_base = '0;
   logic [ADDR_W-1:0] img_size = '0;

   lookup_rsp_t pending_rsp[$];
   int          fail_count = 0;
   bit          quiet = 1'b0;

   function automatic bit stays_ahead(int unsigned i, lookup_req_t r);
      if (sym_start[i] != r.address) return sym_start[i] < r.address;
      if (sym_len[i] != r.length) return sym_len[i] > r.length;
      return sym_kind[i] <= r.kind;
   endfunction

   function automatic lookup_rsp_t resolve_symbol(lookup_req_t r);
      lookup_rsp_t       o;
      logic [ADDR_W-1:0] ofs, delta;
      int unsigned       lo, hi, mid, k, hit;
      bit                found, inside_fn;
      o = '0;
      found = 0;
      inside_fn = 0;
      hit = 0;
      case (r.action)
         ACT_INSERT: begin
            if (r.address == '0) o.status = STS_IGNORED;
            else if (sym_count >= DEPTH) o.status = STS_FULL;
            else begin
               k = sym_count;
               while (k > 0 && !stays_ahead(k - 1, r)) begin
                  sym_start[k] = sym_start[k-1];
                  sym_len[k]   = sym_len[k-1];
                  sym_kind[k]  = sym_kind[k-1];
                  sym_func[k]  = sym_func[k-1];
                  sym_id[k]    = sym_id[k-1];
                  k--;
               end
               sym_start[k] = r.address;
               sym_len[k]   = r.length;
               sym_kind[k]  = r.kind;
               sym_func[k]  = r.is_func;
               sym_id[k]    = r.id;
               sym_count++;
               o.status = STS_OK;
            end
         end
         ACT_CLEAR: sym_count = 0;
         ACT_RESOLVE: begin
            if (r.is_offset) begin
               ofs = r.address;
               o.full_address = (img_base != '0) ? img_base + r.address : r.address;
            end else begin
               o.full_address = r.address;
               ofs = r.address;
               if (img_base != '0 && r.address >= img_base &&
                   r.address < img_base + img_size)
                  ofs = r.address - img_base;
            end
            lo = 0;
            hi = sym_count;
            while (lo < hi) begin
               mid = lo + (hi - lo) / 2;
               if (sym_start[mid] <= ofs) lo = mid + 1;
               else hi = mid;
            end
            k = lo;
            while (k > 0) begin
               k--;
               if (sym_func[k] && sym_start[k] <= ofs) begin
                  delta = ofs - sym_start[k];
                  if (sym_len[k] == '0) begin
                     if (delta == '0) begin
                        hit = k; found = 1; inside_fn = 1;
                        break;
                     end
                  end else if (delta < {32'd0, sym_len[k]}) begin
                     hit = k; found = 1; inside_fn = 1;
                     break;
                  end else if (delta > WALK_LIMIT) break;
               end
            end
            if (!found && lo > 0) begin
               hit = lo - 1;
               found = 1;
            end
            o.image_offset = ofs;
            if (!found) o.status = STS_NONE;
            else begin
               o.status = STS_OK;
               o.found_id = sym_id[hit];
               o.found_start = sym_start[hit];
               o.offset_into = ofs - sym_start[hit];
               o.by_containment = inside_fn;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // one beat on the request channel; the caller sits just after a rising edge
   task automatic send_lookup(lookup_req_t r, bit typed = 0, lookup_rsp_t exp_rsp = '0);
      lookup_rsp_t p;
      int          gap;
      req_valid <= 1'b1;
      req_action <= r.action;
      req_address <= r.address;
      req_address_is_offset <= r.is_offset;
      req_length <= r.length;
      req_kind_code <= r.kind;
      req_is_function <= r.is_func;
      req_entry_id <= r.id;
      do @(posedge clock); while (req_stall);
      p = resolve_symbol(r);
      pending_rsp.push_back(typed ? exp_rsp : p);
      if (!quiet && $urandom_range(3) == 0) begin
         gap = $urandom_range(18, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it
   task automatic write_reg(reg_index_type idx, logic [ADDR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_IMAGE_BASE) img_base = val;
      else img_size = val;
   endtask

   function automatic lookup_req_t mk(logic [1:0] a, logic [ADDR_W-1:0] ad, logic of,
                                      logic [LEN_W-1:0] ln, logic [KIND_W-1:0] kd,
                                      logic fn, logic [ID_W-1:0] id);
      lookup_req_t r;
      r = '{a, ad, of, ln, kd, fn, id};
      return r;
   endfunction

   function automatic lookup_rsp_t rs(logic [1:0] s, logic [ADDR_W-1:0] io,
                                      logic [ADDR_W-1:0] fa);
      lookup_rsp_t o;
      o = '0;
      o.status = s;
      o.image_offset = io;
      o.full_address = fa;
      return o;
   endfunction

   // random beat aimed at a region of offsets near region_lo
   function automatic lookup_req_t random_lookup(logic [ADDR_W-1:0] region_lo);
      lookup_req_t r;
      int unsigned pick;
      logic [ADDR_W-1:0] ofs;
      r = '0;
      r.kind = KIND_W'($urandom);
      r.is_func = ($urandom_range(3) != 0);
      r.id = ID_W'($urandom);
      r.is_offset = 1'($urandom);
      ofs = region_lo + ADDR_W'($urandom_range(32'h0040_0000));
      pick = $urandom_range(99);
      case ($urandom_range(9))
         0: r.length = $urandom;
         1: r.length = '0;
         default: r.length = $urandom_range(32'h2_0000);
      endcase
      if (pick < 55) begin
         r.action = ACT_INSERT;
         r.address = ($urandom_range(30) == 0) ? '0 :
                     ($urandom_range(30) == 0) ? {$urandom, $urandom} : ofs;
      end else if (pick < 96) begin
         r.action = ACT_RESOLVE;
         case ($urandom_range(5))
            0: r.address = {$urandom, $urandom};
            1: r.address = img_base + ofs;
            default: r.address = ofs;
         endcase
      end else if (pick < 98) r.action = ACT_CLEAR;
      else r.action = ACT_RSVD;
      if (r.action == ACT_RESOLVE && !r.is_offset && $urandom_range(1))
         r.address = img_base + ofs;
      return r;
   endfunction

   // result checking
   always @(posedge clock) begin
      lookup_rsp_t w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_status !== w.status) begin
               $error("status exp %0d got %0d", w.status, rsp_status); fail_count++;
            end
            if (rsp_found_id !== w.found_id) begin
               $error("found_id exp %h got %h", w.found_id, rsp_found_id); fail_count++;
            end
            if (rsp_found_start !== w.found_start) begin
               $error("found_start exp %h got %h", w.found_start, rsp_found_start);
               fail_count++;
            end
            if (rsp_offset_into !== w.offset_into) begin
               $error("offset_into exp %h got %h", w.offset_into, rsp_offset_into);
               fail_count++;
            end
            if (rsp_image_offset !== w.image_offset) begin
               $error("image_offset exp %h got %h", w.image_offset, rsp_image_offset);
               fail_count++;
            end
            if (rsp_full_address !== w.full_address) begin
               $error("full_address exp %h got %h", w.full_address, rsp_full_address);
               fail_count++;
            end
            if (rsp_by_containment !== w.by_containment) begin
               $error("by_containment exp %b got %b", w.by_containment, rsp_by_containment);
               fail_count++;
            end
         end
      end
   end

   // receiver backpressure in bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(2) == 0);
         stall_left <= $urandom_range(18, 1);
      end
   end

   initial begin
      #30ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      directed_row_t     rows[$];
      logic [ADDR_W-1:0] bases[5];
      logic [ADDR_W-1:0] sizes[5];
      logic [ADDR_W-1:0] region;
      int                n;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back('{mk(ACT_RESOLVE, ALL1, 0, 0, 0, 0, 0), 1, rs(STS_NONE, ALL1, ALL1)});
      rows.push_back('{mk(ACT_INSERT, 0, 0, 5, 1, 1, 9), 1, rs(STS_IGNORED, 0, 0)});
      rows.push_back('{mk(ACT_INSERT, 64'h1000, 0, 32'h100, 3, 1, 16'hFFFF), 1,
                       rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_INSERT, 64'h1000, 0, 32'h200, 0, 0, 1), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_INSERT, 64'h1000, 0, 32'h100, 3, 1, 2), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_INSERT, 64'h1000, 0, 32'h100, 15, 1, 3), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_INSERT, ALL1, 0, '1, 0, 1, 4), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_INSERT, 64'h5000, 0, 0, 7, 1, 5), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_INSERT, 64'h40_0000, 0, 32'h10, 1, 1, 6), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_INSERT, 64'h40_0100, 0, 32'h8, 2, 0, 7), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_RESOLVE, 64'h1050, 0, 0, 0, 0, 0), 0, lookup_rsp_t'('0)});
      rows.push_back('{mk(ACT_RESOLVE, 64'h1180, 0, 0, 0, 0, 0), 0, lookup_rsp_t'('0)});
      rows.push_back('{mk(ACT_RESOLVE, 64'h5000, 1, 0, 0, 0, 0), 0, lookup_rsp_t'('0)});
      rows.push_back('{mk(ACT_RESOLVE, 64'h5001, 0, 0, 0, 0, 0), 0, lookup_rsp_t'('0)});
      // far past every function below it: walk gives up, nearest entry wins
      rows.push_back('{mk(ACT_RESOLVE, 64'h30_0000, 0, 0, 0, 0, 0), 0, lookup_rsp_t'('0)});
      rows.push_back('{mk(ACT_RESOLVE, 64'h40_0200, 0, 0, 0, 0, 0), 0, lookup_rsp_t'('0)});
      rows.push_back('{mk(ACT_RESOLVE, ALL1, 1, 0, 0, 0, 0), 0, lookup_rsp_t'('0)});
      rows.push_back('{mk(ACT_RESOLVE, 0, 0, 0, 0, 0, 0), 1, rs(STS_NONE, 0, 0)});
      rows.push_back('{mk(ACT_RSVD, 64'h1000, 1, '1, 15, 1, 16'hFFFF), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0), 1, rs(STS_OK, 0, 0)});
      rows.push_back('{mk(ACT_RESOLVE, 64'h1050, 0, 0, 0, 0, 0), 1,
                       rs(STS_NONE, 64'h1050, 64'h1050)});
      foreach (rows[i]) send_lookup(rows[i].req, rows[i].typed, rows[i].rsp);

      // fill the table to the top, then overflow it
      for (int i = 0; i < DEPTH; i++)
         send_lookup(mk(ACT_INSERT, 64'h1_0000 + i * 64'h40, 0, 32'h40, KIND_W'($urandom),
                        (i % 3) != 0, ID_W'($urandom)));
      send_lookup(mk(ACT_INSERT, 64'h2000, 0, 4, 0, 1, 1));
      for (int i = 0; i < 12; i++)
         send_lookup(mk(ACT_RESOLVE, 64'h1_0000 + $urandom_range(DEPTH * 64 + 64'h20_0000),
                        0, 0, 0, 0, 0));
      send_lookup(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
      drain();

      bases = '{64'h0, 64'h0000_7FF0_0000_0000, 64'hFFFF_FFFF_FFFF_F000,
                {$urandom, $urandom}, ALL1};
      sizes = '{ALL1, 64'h0100_0000, ALL1, {$urandom, $urandom}, 64'h0};
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(REG_IMAGE_BASE, bases[ph]);
         write_reg(REG_IMAGE_SIZE, sizes[ph]);
         csr_valid <= 1'b0;
         @(posedge clock);
         quiet = (ph == 4);
         region = (ph == 3) ? {$urandom, 32'd0} : 64'h1_0000;
         n = 0;
         while (n < 130) begin
            send_lookup(random_lookup(region));
            n++;
            if (sym_count > 70) begin
               send_lookup(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
               n++;
            end
            // at most one hold-off until the block has caught up
            if (ph == 2 && n == 60) drain();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire

// ===== address_to_symbol_resolver.f =====
rtl/atsr_pkg.sv
rtl/atsr_mem.sv
rtl/address_to_symbol_resolver.sv
dv/tb_top.sv
